// ===== rtl/core/ant_pkg.sv =====
// ant_pkg: shared types and constants of the aging neighbor table
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps

package ant_pkg;

  localparam int ID_W        = 8;
  localparam int STAMP_W     = 32;
  localparam int BYTE_W      = 8;
  localparam int DIST_W      = 8;
  localparam int COUNT_OUT_W = 4;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_CEIL = 4'd1;

  localparam logic [STAMP_W-1:0] AGE_LIMIT_RST = 32'd64;
  localparam logic [DIST_W-1:0]  DIST_CEIL_RST = 8'd90;

  // operation codes of an input item
  localparam logic OP_MESSAGE = 1'b0;
  localparam logic OP_PURGE   = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
    logic [BYTE_W-1:0]  first;
    logic [BYTE_W-1:0]  second;
    logic [DIST_W-1:0]  distance;
  } ant_entry_t;

  typedef struct packed {
    logic [STAMP_W-1:0] age_limit;
    logic [DIST_W-1:0]  dist_ceil;
  } ant_cfg_t;

endpackage

// ===== rtl/core/ant_mem.sv =====
// ant_mem: neighbor entry storage, one write port and two registered read ports
// depends on ant_pkg for the entry type
`timescale 1ns / 1ps

module ant_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ant_pkg::ant_entry_t wr_data,
  input  logic [AW-1:0]       rd_a_addr,
  output ant_pkg::ant_entry_t rd_a_data,
  input  logic [AW-1:0]       rd_b_addr,
  output ant_pkg::ant_entry_t rd_b_data
);
  import ant_pkg::*;

  ant_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data registered
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ===== rtl/core/ant_cfg.sv =====
// ant_cfg: configuration registers, age limit and distance ceiling
// depends on ant_pkg for register indexes, reset values and the cfg struct
`timescale 1ns / 1ps

module ant_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ant_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ant_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ant_pkg::ant_cfg_t                 cfg_o
);
  import ant_pkg::*;

  ant_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  // unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.age_limit <= AGE_LIMIT_RST;
      cfg_r.dist_ceil <= DIST_CEIL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AGE_LIMIT: cfg_r.age_limit <= cfg_data[STAMP_W-1:0];
        REG_DIST_CEIL: cfg_r.dist_ceil <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/aging_neighbor_table_unit.sv =====
// aging neighbor table: a message scans every held entry on read port a, one
// entry a cycle, then writes its entry back over a match or appends it while room
// remains (an empty table goes straight to the write-back); a purge walks entries
// from the last down, a read state and an age check state per entry, then scans
// the entries left; one item at a time, a new one only once the result is registered
// synchronous active-low reset clears control, count and configuration;
// the entry memory is not cleared and only entries below the count are read
`timescale 1ns / 1ps

module aging_neighbor_table_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input item channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic [ant_pkg::ID_W-1:0]           in_sender_id,
  input  logic [ant_pkg::BYTE_W-1:0]         in_payload_first,
  input  logic [ant_pkg::BYTE_W-1:0]         in_payload_second,
  input  logic [ant_pkg::DIST_W-1:0]         in_distance_mm,
  input  logic [ant_pkg::STAMP_W-1:0]        in_now_ticks,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ant_pkg::COUNT_OUT_W-1:0]    out_entry_count,
  output logic [ant_pkg::DIST_W-1:0]         out_nearest_distance,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ant_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ant_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ant_pkg::*;

  // address and count share one width: the count never passes CAPACITY-1
  localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam logic [AW-1:0] FULL_COUNT = AW'(CAPACITY - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0; // waiting for an input transfer
  localparam logic [2:0] S_SCAN = 3'd1; // issuing reads 0..count-1
  localparam logic [2:0] S_TAIL = 3'd2; // last read data being evaluated
  localparam logic [2:0] S_MWR  = 3'd3; // message write-back
  localparam logic [2:0] S_PRD  = 3'd4; // purge read of entry k and last entry
  localparam logic [2:0] S_PEV  = 3'd5; // purge age check and move of last entry
  localparam logic [2:0] S_DONE = 3'd6; // result ready for the output register

  ant_cfg_t cfg;

  logic [2:0]         state_r,    state_nxt;
  logic [AW-1:0]      count_r,    count_nxt;
  logic [AW-1:0]      idx_r,      idx_nxt;      // scan index, or k while purging
  logic [AW-1:0]      eval_idx_r, eval_idx_nxt; // address of the data now on port a
  logic               pend_r,     pend_nxt;     // port a data is a scan read
  logic               found_r,    found_nxt;
  logic [AW-1:0]      slot_r,     slot_nxt;
  logic [DIST_W-1:0]  min_r,      min_nxt;
  logic               msg_r,      msg_nxt;
  ant_entry_t         item_r,     item_nxt;     // message fields, stamp = now
  logic               out_valid_r,   out_valid_nxt;
  logic [AW-1:0]      out_count_r,   out_count_nxt;
  logic [DIST_W-1:0]  out_near_r,    out_near_nxt;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  ant_entry_t         wr_data;
  logic [AW-1:0]      rd_a_addr;
  logic [AW-1:0]      rd_b_addr;
  ant_entry_t         rd_a_data;
  ant_entry_t         rd_b_data;

  logic [STAMP_W-1:0] age;
  logic               aged;
  logic [AW-1:0]      count_after;

  ant_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  ant_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  // only one item in flight; a finished result may still sit in the output register
  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_entry_count      = COUNT_OUT_W'(out_count_r);
  assign out_nearest_distance = out_near_r;

  // port a walks the scan or points at entry k, port b always at the last entry
  assign rd_a_addr = idx_r;
  assign rd_b_addr = count_r - AW'(1);

  // wrap-around age of entry k against the purge time
  assign age         = item_r.stamp - rd_a_data.stamp;
  assign aged        = (age > cfg.age_limit);
  assign count_after = aged ? (count_r - AW'(1)) : count_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    eval_idx_nxt  = eval_idx_r;
    pend_nxt      = 1'b0;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    min_nxt       = min_r;
    msg_nxt       = msg_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_near_nxt  = out_near_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_b_data;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // evaluate the scan read issued last cycle: ids are unique in the table,
    // so a message's min runs over every other entry and adds its own distance later when stored
    if (pend_r) begin
      if (msg_r && (rd_a_data.id == item_r.id)) begin
        found_nxt = 1'b1;
        slot_nxt  = eval_idx_r;
      end else if (rd_a_data.distance < min_r) begin
        min_nxt = rd_a_data.distance;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          msg_nxt           = (in_operation == OP_MESSAGE);
          item_nxt.id       = in_sender_id;
          item_nxt.stamp    = in_now_ticks;
          item_nxt.first    = in_payload_first;
          item_nxt.second   = in_payload_second;
          item_nxt.distance = in_distance_mm;
          found_nxt         = 1'b0;
          min_nxt           = cfg.dist_ceil;
          if (in_operation == OP_MESSAGE) begin
            idx_nxt   = '0;
            state_nxt = (count_r == '0) ? S_MWR : S_SCAN;
          end else begin
            idx_nxt   = count_r - AW'(1);
            state_nxt = (count_r == '0) ? S_DONE : S_PRD;
          end
        end
      end
      S_SCAN: begin
        pend_nxt     = 1'b1;
        eval_idx_nxt = idx_r;
        if (idx_r == count_r - AW'(1)) begin
          state_nxt = S_TAIL;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_TAIL: begin
        state_nxt = msg_r ? S_MWR : S_DONE;
      end
      S_MWR: begin
        wr_data = item_r;
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = slot_r;
        end else if (count_r != FULL_COUNT) begin
          // append a new sender
          wr_en     = 1'b1;
          wr_addr   = count_r;
          count_nxt = count_r + AW'(1);
        end
        if ((found_r || (count_r != FULL_COUNT)) && (item_r.distance < min_r)) begin
          min_nxt = item_r.distance;
        end
        state_nxt = S_DONE;
      end
      S_PRD: begin
        state_nxt = S_PEV;
      end
      S_PEV: begin
        // aged entry k is replaced by the current last entry
        if (aged) begin
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = rd_b_data;
        end
        count_nxt = count_after;
        if (idx_r == '0) begin
          idx_nxt   = '0;
          state_nxt = (count_after == '0) ? S_DONE : S_SCAN;
        end else begin
          idx_nxt   = idx_r - AW'(1);
          state_nxt = S_PRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          out_near_nxt  = min_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    eval_idx_r  <= eval_idx_nxt;
    found_r     <= found_nxt;
    slot_r      <= slot_nxt;
    min_r       <= min_nxt;
    msg_r       <= msg_nxt;
    item_r      <= item_nxt;
    out_count_r <= out_count_nxt;
    out_near_r  <= out_near_nxt;
  end

endmodule

// ===== rtl/core/ant_checker.sv =====
// ant_checker: port-level checks of the aging neighbor table, bound to the top level
// depends on ant_pkg for field widths and on aging_neighbor_table_unit for the bind
`timescale 1ns / 1ps

module ant_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [ant_pkg::COUNT_OUT_W-1:0]    out_entry_count,
  input logic [ant_pkg::DIST_W-1:0]         out_nearest_distance,
  input logic                               cfg_valid,
  input logic                               cfg_ready
);

  // no result is left over from before reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one item at a time: the block is busy the cycle after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_entry_count) && $stable(out_nearest_distance)))
    else $error("stalled result changed or dropped");

  // configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind aging_neighbor_table_unit ant_checker u_ant_checker (.*);
